// File: hw/rtl/hap_pkg.sv
// ----------------------------------------------------------------------------
// Histogram autocorrelation peak package
// Shared widths, register map, reset values and sequencer states.
// ----------------------------------------------------------------------------
package hap_pkg;

  localparam int DEF_MAX_BINS = 1024;
  localparam int BIN_W        = 16;
  localparam int LAG_W        = 11;
  localparam int ACF_W        = 32;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [LAG_W-1:0] LAG_START_RST = LAG_W'(200);
  localparam logic [LAG_W-1:0] LAG_STOP_RST  = LAG_W'(600);

  localparam logic REG_LAG_START = 1'b0;
  localparam logic REG_LAG_STOP  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAG,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_DSTART,
    ST_DIV,
    ST_MEAN,
    ST_MWAIT,
    ST_OUT
  } state_t;

endpackage

// File: hw/rtl/histogram_autocorrelation_peak.sv
// ----------------------------------------------------------------------------
// Histogram autocorrelation peak
// Loads a histogram, then reports the peak and mean normalized autocorrelation.
// ----------------------------------------------------------------------------
// Bins load at one item per cycle into an internal store. The item that carries
// last_bin starts the compute phase, during which in_stall stays high: for each
// lag k in [lag_start, lag_stop) below the length len, a single multiplier walks
// the len-k bin pairs through the read, multiply and accumulate states, then one
// shared restoring divider normalizes the sum by len-k. A final pass of the same
// divider divides the sum of the normalized values by len to form mean_acf.
// Results wait in an output register; a bin that arrives with the store full is
// dropped and reported through overflowed.
// ----------------------------------------------------------------------------
module histogram_autocorrelation_peak
  import hap_pkg::*;
#(
  parameter int MAX_BINS = DEF_MAX_BINS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BIN_W-1:0]   bin_value,
  input  logic               last_bin,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ACF_W-1:0]   max_acf,
  output logic [ACF_W-1:0]   mean_acf,
  output logic               overflowed
);

  localparam int AW = $clog2(MAX_BINS);
  localparam int CW = $clog2(MAX_BINS + 1);
  localparam int DW = ACF_W + AW;
  localparam int KW = (CW > LAG_W) ? CW : LAG_W;

  state_t state, state_next;

  logic [LAG_W-1:0]   lag_start;
  logic [LAG_W-1:0]   lag_stop;
  logic [CW-1:0]      count;
  logic [CW-1:0]      len;
  logic               ovf;
  logic [LAG_W-1:0]   k;
  logic [CW-1:0]      i;
  logic [BIN_W-1:0]   rd_a;
  logic [BIN_W-1:0]   rd_b;
  logic [2*BIN_W-1:0] prod;
  logic [DW-1:0]      acc;
  logic [DW-1:0]      total;
  logic [ACF_W-1:0]   run_max;
  logic [ACF_W-1:0]   mean_q;

  logic               cfg_wr;
  logic               in_acc;
  logic               has_room;
  logic [CW-1:0]      len_after;
  logic               lag_go;
  logic               last_pair;
  logic [KW-1:0]      pair_gap;
  logic [CW-1:0]      len_minus_k;
  logic               out_free;
  logic               div_start;
  logic               div_done;
  logic [DW-1:0]      div_dividend;
  logic [CW-1:0]      div_divisor;
  logic [DW-1:0]      div_quot;
  logic [ACF_W-1:0]   r_val;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_LAG_STOP) ? PDATA_W'(lag_stop) : PDATA_W'(lag_start);

  always_ff @(posedge clk) begin
    if (rst) begin
      lag_start <= LAG_START_RST;
      lag_stop  <= LAG_STOP_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LAG_START) begin
        lag_start <= pwdata[LAG_W-1:0];
      end else begin
        lag_stop <= pwdata[LAG_W-1:0];
      end
    end
  end

  assign in_acc      = in_valid && !in_stall;
  assign has_room    = count < CW'(MAX_BINS);
  assign len_after   = has_room ? CW'(count + CW'(1)) : count;
  assign lag_go      = (KW'(k) < KW'(lag_stop)) && (KW'(k) < KW'(len));
  assign last_pair   = CW'(i + CW'(1)) == len;
  assign pair_gap    = KW'(i) - KW'(k);
  assign len_minus_k = CW'(KW'(len) - KW'(k));
  assign out_free    = !out_valid || !out_stall;
  assign r_val       = div_quot[ACF_W-1:0];

  assign div_dividend = (state == ST_MEAN) ? total : acc;
  assign div_divisor  = (state == ST_MEAN) ? len : len_minus_k;

  hap_bin_mem #(
    .DEPTH (MAX_BINS),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (in_acc && has_room),
    .wr_addr   (count[AW-1:0]),
    .wr_data   (bin_value),
    .rd_addr_a (i[AW-1:0]),
    .rd_addr_b (pair_gap[AW-1:0]),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  hap_div #(
    .DW (DW),
    .VW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && last_bin) begin
          state_next = ST_LAG;
        end
      end
      ST_LAG: begin
        state_next = lag_go ? ST_RD : ST_MEAN;
      end
      ST_RD: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_ACC;
      end
      ST_ACC: begin
        state_next = last_pair ? ST_DSTART : ST_RD;
      end
      ST_DSTART: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_LAG;
        end
      end
      ST_MEAN: begin
        div_start  = 1'b1;
        state_next = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (in_acc) begin
      if (has_room) begin
        count <= CW'(count + CW'(1));
      end else begin
        ovf <= 1'b1;
      end
    end else if (state == ST_OUT && out_free) begin
      count <= '0;
      ovf   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_acc && last_bin) begin
          len     <= len_after;
          k       <= lag_start;
          run_max <= '0;
          total   <= '0;
        end
      end
      ST_LAG: begin
        i   <= CW'(k);
        acc <= '0;
      end
      ST_MUL: begin
        prod <= rd_a * rd_b;
      end
      ST_ACC: begin
        acc <= acc + DW'(prod);
        i   <= CW'(i + CW'(1));
      end
      ST_DIV: begin
        if (div_done) begin
          if (r_val > run_max) begin
            run_max <= r_val;
          end
          total <= total + DW'(r_val);
          k     <= LAG_W'(k + LAG_W'(1));
        end
      end
      ST_MWAIT: begin
        if (div_done) begin
          mean_q <= r_val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      max_acf    <= run_max;
      mean_acf   <= mean_q;
      overflowed <= ovf;
    end
  end

endmodule

// File: hw/rtl/hap_bin_mem.sv
// ----------------------------------------------------------------------------
// Histogram bin store
// One write port and two registered read ports.
// ----------------------------------------------------------------------------
module hap_bin_mem
  import hap_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_BINS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [BIN_W-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [BIN_W-1:0] rd_data_a,
  output logic [BIN_W-1:0] rd_data_b
);

  logic [BIN_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// File: hw/rtl/hap_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned quotient, one bit per cycle, done pulses when quotient is ready.
// ----------------------------------------------------------------------------
module hap_div
  import hap_pkg::*;
#(
  parameter int DW = ACF_W + 10,
  parameter int VW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [VW-1:0]   rem;
  logic [VW-1:0]   dvs;
  logic [VW:0]     rem_sh;
  logic            fits;

  assign rem_sh = {rem, quotient[DW-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNTW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DW);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem      <= VW'(rem_sh - {1'b0, dvs});
        quotient <= {quotient[DW-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[VW-1:0];
        quotient <= {quotient[DW-2:0], 1'b0};
      end
    end
  end

endmodule
